// ----- rtl/sf64_pkg.sv -----
`default_nettype none
package sf64_pkg;

    typedef logic [4:0] t_op;

    // datapath commands
    localparam t_op OP_NONE    = 5'd0;
    localparam t_op OP_LOAD    = 5'd1;
    localparam t_op OP_IDX_CLR = 5'd2;
    localparam t_op OP_IDX_INC = 5'd3;
    localparam t_op OP_TDIV_GO = 5'd4;
    localparam t_op OP_MR_INIT = 5'd5;
    localparam t_op OP_MR_SHFT = 5'd6;
    localparam t_op OP_BDIV_GO = 5'd7;
    localparam t_op OP_POW_INI = 5'd8;
    localparam t_op OP_MUL_AB  = 5'd9;
    localparam t_op OP_ACC_LD  = 5'd10;
    localparam t_op OP_MUL_BB  = 5'd11;
    localparam t_op OP_B_LD    = 5'd12;
    localparam t_op OP_W_INIT  = 5'd13;
    localparam t_op OP_MUL_WW  = 5'd14;
    localparam t_op OP_W_LD    = 5'd15;
    localparam t_op OP_RHO_INI = 5'd16;
    localparam t_op OP_XY_INIT = 5'd17;
    localparam t_op OP_MUL_XX  = 5'd18;
    localparam t_op OP_X_LD    = 5'd19;
    localparam t_op OP_MUL_YY  = 5'd20;
    localparam t_op OP_Y_LD    = 5'd21;
    localparam t_op OP_GCD_INI = 5'd22;
    localparam t_op OP_GCD_GO  = 5'd23;
    localparam t_op OP_GCD_LD  = 5'd24;
    localparam t_op OP_C_INC   = 5'd25;
    localparam t_op OP_F_TWO   = 5'd26;
    localparam t_op OP_F_G     = 5'd27;
    localparam t_op OP_QDIV_GO = 5'd28;
    localparam t_op OP_RES_OK  = 5'd29;
    localparam t_op OP_RES_REJ = 5'd30;
    localparam t_op OP_RES_GUP = 5'd31;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_GAVEUP = 2'd2;

    localparam logic [3:0] TRIAL_LAST = 4'd11;
    localparam logic [3:0] BASE_END   = 4'd7;

    typedef struct packed {
        logic n_lt4;
        logic n_eq_prime;
        logic n_even;
        logic d_odd;
        logic idx_trial_end;
        logic idx_base_end;
        logic e_zero;
        logic e_lsb;
        logic w_one;
        logic w_nm1;
        logic k_lt_s;
        logic c_ge_n;
        logic step_cap;
        logic gb_zero;
        logic g_one;
        logic g_n;
        logic rem_zero;
        logic mul_done;
        logic div_done;
        logic mul_busy;
        logic div_busy;
    } t_sts;

    function automatic logic [63:0] prime_at(input logic [3:0] idx);
        logic [63:0] p;
        unique case (idx)
            4'd0:    p = 64'd2;
            4'd1:    p = 64'd3;
            4'd2:    p = 64'd5;
            4'd3:    p = 64'd7;
            4'd4:    p = 64'd11;
            4'd5:    p = 64'd13;
            4'd6:    p = 64'd17;
            4'd7:    p = 64'd19;
            4'd8:    p = 64'd23;
            4'd9:    p = 64'd29;
            4'd10:   p = 64'd31;
            4'd11:   p = 64'd37;
            default: p = 64'd1;
        endcase
        return p;
    endfunction

    function automatic logic [63:0] base_at(input logic [3:0] idx);
        logic [63:0] b;
        unique case (idx)
            4'd0:    b = 64'd2;
            4'd1:    b = 64'd325;
            4'd2:    b = 64'd9375;
            4'd3:    b = 64'd28178;
            4'd4:    b = 64'd450775;
            4'd5:    b = 64'd9780504;
            4'd6:    b = 64'd1795265022;
            default: b = 64'd1;
        endcase
        return b;
    endfunction

    // modular add, both operands below m
    function automatic logic [63:0] addm(input logic [63:0] a, input logic [63:0] b,
                                         input logic [63:0] m);
        logic [64:0] s;
        logic [64:0] t;
        s = {1'b0, a} + {1'b0, b};
        t = s - {1'b0, m};
        return (s >= {1'b0, m}) ? t[63:0] : s[63:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/semiprime_factorizer_64.sv -----
`default_nettype none
// channel | valid      | ready       | payload
// in      | i_in_valid | o_in_ready  | i_number
// out     | o_out_valid| i_out_ready | o_small_factor, o_large_factor, o_status
//
// One request at a time; a new request is taken once the previous one is
// finished, even while its result still waits in the output register.
// Work per request: trial division by 12 primes, each Miller-Rabin modular
// multiply done by double-and-add (one bit a cycle), each rho iteration
// 3 multiplies plus a gcd with one divide per remainder step. The shared
// serial multiplier and the shared divider set the time taken.
// Reset (synchronous, active low) returns the controller to idle and drops
// any pending result; output stalls only hold the finished result.
module semiprime_factorizer_64 import sf64_pkg::*; #(
    parameter logic [31:0] MAX_STEPS = 32'd16777216
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_number,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_small_factor,
    output logic [63:0]      o_large_factor,
    output logic [1:0]       o_status
);
    t_op  op;
    t_sts sts;

    // sequence the search
    sf64_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sts(sts), .o_op(op)
    );

    // hold the operands, the shared multiplier and divider, and the result
    sf64_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(op), .i_number(i_number),
        .o_sts(sts), .o_small_factor(o_small_factor),
        .o_large_factor(o_large_factor), .o_status(o_status)
    );
endmodule
`default_nettype wire

// ----- rtl/sf64_mulmod.sv -----
`default_nettype none
module sf64_mulmod import sf64_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    input  wire logic [63:0] i_m,
    output logic             o_busy,
    output logic             o_done,
    output logic [63:0]      o_res
);
    logic        r_busy;
    logic [63:0] r_a, r_b, r_acc, r_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_b == 64'd0) begin
            r_busy <= 1'b0;
        end
    end

    // double-and-add, one multiplier bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_acc <= 64'd0;
        end else if (r_busy && r_b != 64'd0) begin
            if (r_b[0]) begin
                r_acc <= addm(r_acc, r_a, r_m);
            end
            r_a <= addm(r_a, r_a, r_m);
            r_b <= {1'b0, r_b[63:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_b == 64'd0);
    assign o_res  = r_acc;
endmodule
`default_nettype wire

// ----- rtl/sf64_div.sv -----
`default_nettype none
module sf64_div import sf64_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [63:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [63:0]      o_quo,
    output logic [63:0]      o_rem
);
    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_q, r_r, r_d;
    logic [64:0] trial, diff;
    logic        ge;

    always_comb begin
        trial = {r_r, r_q[63]};
        diff  = trial - {1'b0, r_d};
        ge    = trial >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 7'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
        end else if (r_busy) begin
            if (r_cnt == 7'd0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 7'd1;
            end
        end
    end

    // restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= 64'd0;
            r_d <= i_divisor;
        end else if (r_busy && r_cnt != 7'd0) begin
            r_r <= ge ? diff[63:0] : trial[63:0];
            r_q <= {r_q[62:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_cnt == 7'd0);
    assign o_quo  = r_q;
    assign o_rem  = r_r;
endmodule
`default_nettype wire

// ----- rtl/sf64_dp.sv -----
`default_nettype none
module sf64_dp import sf64_pkg::*; #(
    parameter logic [31:0] MAX_STEPS = 32'd16777216
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_op         i_op,
    input  wire logic [63:0] i_number,
    output t_sts             o_sts,
    output logic [63:0]      o_small_factor,
    output logic [63:0]      o_large_factor,
    output logic [1:0]       o_status
);
    logic [63:0] r_n, r_d, r_acc, r_b, r_e, r_x, r_y, r_c, r_ga, r_gb, r_f;
    logic [63:0] r_small, r_large;
    logic [1:0]  r_status;
    logic [3:0]  r_idx;
    logic [5:0]  r_s, r_k;
    logic [31:0] r_steps;

    logic        mul_go, mul_busy, mul_done;
    logic [63:0] mul_a, mul_b, mul_res;
    logic        div_go, div_busy, div_done;
    logic [63:0] div_x, div_y, div_quo, div_rem;
    logic [63:0] nm1;

    assign nm1 = r_n - 64'd1;

    always_comb begin
        mul_go = 1'b1;
        mul_a  = r_acc;
        mul_b  = r_b;
        unique case (i_op)
            OP_MUL_AB: begin mul_a = r_acc; mul_b = r_b;   end
            OP_MUL_BB: begin mul_a = r_b;   mul_b = r_b;   end
            OP_MUL_WW: begin mul_a = r_acc; mul_b = r_acc; end
            OP_MUL_XX: begin mul_a = r_x;   mul_b = r_x;   end
            OP_MUL_YY: begin mul_a = r_y;   mul_b = r_y;   end
            default:   mul_go = 1'b0;
        endcase
    end

    always_comb begin
        div_go = 1'b1;
        div_x  = r_n;
        div_y  = r_f;
        unique case (i_op)
            OP_TDIV_GO: begin div_x = r_n;            div_y = prime_at(r_idx); end
            OP_BDIV_GO: begin div_x = base_at(r_idx); div_y = r_n;             end
            OP_GCD_GO:  begin div_x = r_ga;           div_y = r_gb;            end
            OP_QDIV_GO: begin div_x = r_n;            div_y = r_f;             end
            default:    div_go = 1'b0;
        endcase
    end

    sf64_mulmod u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_go),
        .i_a(mul_a), .i_b(mul_b), .i_m(r_n),
        .o_busy(mul_busy), .o_done(mul_done), .o_res(mul_res)
    );

    sf64_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_go),
        .i_dividend(div_x), .i_divisor(div_y),
        .o_busy(div_busy), .o_done(div_done), .o_quo(div_quo), .o_rem(div_rem)
    );

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD:    r_n <= i_number;
            OP_IDX_CLR: r_idx <= 4'd0;
            OP_IDX_INC: r_idx <= r_idx + 4'd1;
            OP_MR_INIT: begin r_d <= nm1; r_s <= 6'd0; end
            OP_MR_SHFT: begin r_d <= {1'b0, r_d[63:1]}; r_s <= r_s + 6'd1; end
            OP_POW_INI: begin r_b <= div_rem; r_acc <= 64'd1; r_e <= r_d; end
            OP_ACC_LD:  r_acc <= mul_res;
            OP_B_LD:    begin r_b <= mul_res; r_e <= {1'b0, r_e[63:1]}; end
            OP_W_INIT:  r_k <= 6'd1;
            OP_W_LD:    begin r_acc <= mul_res; r_k <= r_k + 6'd1; end
            OP_RHO_INI: begin r_c <= 64'd1; r_steps <= 32'd0; end
            OP_XY_INIT: begin r_x <= 64'd2; r_y <= 64'd2; end
            OP_MUL_XX:  r_steps <= r_steps + 32'd1;
            OP_X_LD:    r_x <= addm(mul_res, r_c, r_n);
            OP_Y_LD:    r_y <= addm(mul_res, r_c, r_n);
            OP_GCD_INI: begin
                r_ga <= (r_x > r_y) ? (r_x - r_y) : (r_y - r_x);
                r_gb <= r_n;
            end
            OP_GCD_LD:  begin r_ga <= r_gb; r_gb <= div_rem; end
            OP_C_INC:   r_c <= r_c + 64'd1;
            OP_F_TWO:   r_f <= 64'd2;
            OP_F_G:     r_f <= r_ga;
            OP_RES_OK:  begin
                r_small  <= (r_f < div_quo) ? r_f : div_quo;
                r_large  <= (r_f < div_quo) ? div_quo : r_f;
                r_status <= ST_OK;
            end
            OP_RES_REJ: begin r_small <= 64'd0; r_large <= 64'd0; r_status <= ST_REJECT; end
            OP_RES_GUP: begin r_small <= 64'd0; r_large <= 64'd0; r_status <= ST_GAVEUP; end
            default:    ;
        endcase
    end

    always_comb begin
        o_sts.n_lt4         = r_n < 64'd4;
        o_sts.n_eq_prime    = r_n == prime_at(r_idx);
        o_sts.n_even        = !r_n[0];
        o_sts.d_odd         = r_d[0];
        o_sts.idx_trial_end = r_idx == TRIAL_LAST;
        o_sts.idx_base_end  = r_idx == BASE_END;
        o_sts.e_zero        = r_e == 64'd0;
        o_sts.e_lsb         = r_e[0];
        o_sts.w_one         = r_acc == 64'd1;
        o_sts.w_nm1         = r_acc == nm1;
        o_sts.k_lt_s        = r_k < r_s;
        o_sts.c_ge_n        = r_c >= r_n;
        o_sts.step_cap      = r_steps >= MAX_STEPS;
        o_sts.gb_zero       = r_gb == 64'd0;
        o_sts.g_one         = r_ga == 64'd1;
        o_sts.g_n           = r_ga == r_n;
        o_sts.rem_zero      = div_rem == 64'd0;
        o_sts.mul_done      = mul_done;
        o_sts.div_done      = div_done;
        o_sts.mul_busy      = mul_busy;
        o_sts.div_busy      = div_busy;
    end

    assign o_small_factor = r_small;
    assign o_large_factor = r_large;
    assign o_status       = r_status;
endmodule
`default_nettype wire

// ----- rtl/sf64_ctrl.sv -----
`default_nettype none
module sf64_ctrl import sf64_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_op       o_op
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CHK    = 5'd1;
    localparam logic [4:0] S_TRIAL  = 5'd2;
    localparam logic [4:0] S_TWAIT  = 5'd3;
    localparam logic [4:0] S_SHIFT  = 5'd4;
    localparam logic [4:0] S_BASE   = 5'd5;
    localparam logic [4:0] S_BWAIT  = 5'd6;
    localparam logic [4:0] S_POW    = 5'd7;
    localparam logic [4:0] S_AWAIT  = 5'd8;
    localparam logic [4:0] S_POWB   = 5'd9;
    localparam logic [4:0] S_BBWAIT = 5'd10;
    localparam logic [4:0] S_POWEND = 5'd11;
    localparam logic [4:0] S_SQ     = 5'd12;
    localparam logic [4:0] S_WWAIT  = 5'd13;
    localparam logic [4:0] S_RHO    = 5'd14;
    localparam logic [4:0] S_RC     = 5'd15;
    localparam logic [4:0] S_IT     = 5'd16;
    localparam logic [4:0] S_XWAIT  = 5'd17;
    localparam logic [4:0] S_Y1     = 5'd18;
    localparam logic [4:0] S_Y1WAIT = 5'd19;
    localparam logic [4:0] S_Y2     = 5'd20;
    localparam logic [4:0] S_Y2WAIT = 5'd21;
    localparam logic [4:0] S_GINIT  = 5'd22;
    localparam logic [4:0] S_GCD    = 5'd23;
    localparam logic [4:0] S_GWAIT  = 5'd24;
    localparam logic [4:0] S_GEND   = 5'd25;
    localparam logic [4:0] S_QUOT   = 5'd26;
    localparam logic [4:0] S_QWAIT  = 5'd27;
    localparam logic [4:0] S_OK     = 5'd28;
    localparam logic [4:0] S_REJ    = 5'd29;
    localparam logic [4:0] S_GUP    = 5'd30;

    logic [4:0] r_state, n_state;
    logic       r_valid, n_valid;
    logic       out_free, res_wr;

    assign out_free = !r_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        res_wr  = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin o_op = OP_LOAD; n_state = S_CHK; end
            S_CHK: begin
                if (i_sts.n_lt4) n_state = S_REJ;
                else begin o_op = OP_IDX_CLR; n_state = S_TRIAL; end
            end
            S_TRIAL: begin
                if (i_sts.n_eq_prime) n_state = S_REJ;
                else begin o_op = OP_TDIV_GO; n_state = S_TWAIT; end
            end
            S_TWAIT: if (i_sts.div_done) begin
                if (i_sts.rem_zero) n_state = S_RHO;
                else if (i_sts.idx_trial_end) begin o_op = OP_MR_INIT; n_state = S_SHIFT; end
                else begin o_op = OP_IDX_INC; n_state = S_TRIAL; end
            end
            S_SHIFT: begin
                if (i_sts.d_odd) begin o_op = OP_IDX_CLR; n_state = S_BASE; end
                else o_op = OP_MR_SHFT;
            end
            S_BASE: begin
                if (i_sts.idx_base_end) n_state = S_REJ;
                else begin o_op = OP_BDIV_GO; n_state = S_BWAIT; end
            end
            S_BWAIT: if (i_sts.div_done) begin
                if (i_sts.rem_zero) begin o_op = OP_IDX_INC; n_state = S_BASE; end
                else begin o_op = OP_POW_INI; n_state = S_POW; end
            end
            S_POW: begin
                if (i_sts.e_zero) n_state = S_POWEND;
                else if (i_sts.e_lsb) begin o_op = OP_MUL_AB; n_state = S_AWAIT; end
                else begin o_op = OP_MUL_BB; n_state = S_BBWAIT; end
            end
            S_AWAIT: if (i_sts.mul_done) begin o_op = OP_ACC_LD; n_state = S_POWB; end
            S_POWB:  begin o_op = OP_MUL_BB; n_state = S_BBWAIT; end
            S_BBWAIT: if (i_sts.mul_done) begin o_op = OP_B_LD; n_state = S_POW; end
            S_POWEND: begin
                if (i_sts.w_one || i_sts.w_nm1) begin o_op = OP_IDX_INC; n_state = S_BASE; end
                else begin o_op = OP_W_INIT; n_state = S_SQ; end
            end
            S_SQ: begin
                if (i_sts.w_nm1) begin o_op = OP_IDX_INC; n_state = S_BASE; end
                else if (i_sts.k_lt_s) begin o_op = OP_MUL_WW; n_state = S_WWAIT; end
                else n_state = S_RHO;
            end
            S_WWAIT: if (i_sts.mul_done) begin o_op = OP_W_LD; n_state = S_SQ; end
            S_RHO: begin
                if (i_sts.n_even) begin o_op = OP_F_TWO; n_state = S_QUOT; end
                else begin o_op = OP_RHO_INI; n_state = S_RC; end
            end
            S_RC: begin
                if (i_sts.c_ge_n) n_state = S_GUP;
                else begin o_op = OP_XY_INIT; n_state = S_IT; end
            end
            S_IT: begin
                if (i_sts.step_cap) n_state = S_GUP;
                else begin o_op = OP_MUL_XX; n_state = S_XWAIT; end
            end
            S_XWAIT:  if (i_sts.mul_done) begin o_op = OP_X_LD; n_state = S_Y1; end
            S_Y1:     begin o_op = OP_MUL_YY; n_state = S_Y1WAIT; end
            S_Y1WAIT: if (i_sts.mul_done) begin o_op = OP_Y_LD; n_state = S_Y2; end
            S_Y2:     begin o_op = OP_MUL_YY; n_state = S_Y2WAIT; end
            S_Y2WAIT: if (i_sts.mul_done) begin o_op = OP_Y_LD; n_state = S_GINIT; end
            S_GINIT:  begin o_op = OP_GCD_INI; n_state = S_GCD; end
            S_GCD: begin
                if (i_sts.gb_zero) n_state = S_GEND;
                else begin o_op = OP_GCD_GO; n_state = S_GWAIT; end
            end
            S_GWAIT: if (i_sts.div_done) begin o_op = OP_GCD_LD; n_state = S_GCD; end
            S_GEND: begin
                if (i_sts.g_one) n_state = S_IT;
                else if (i_sts.g_n) begin o_op = OP_C_INC; n_state = S_RC; end
                else begin o_op = OP_F_G; n_state = S_QUOT; end
            end
            S_QUOT:  begin o_op = OP_QDIV_GO; n_state = S_QWAIT; end
            S_QWAIT: if (i_sts.div_done) n_state = S_OK;
            S_OK:  if (out_free) begin o_op = OP_RES_OK;  res_wr = 1'b1; n_state = S_IDLE; end
            S_REJ: if (out_free) begin o_op = OP_RES_REJ; res_wr = 1'b1; n_state = S_IDLE; end
            S_GUP: if (out_free) begin o_op = OP_RES_GUP; res_wr = 1'b1; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (res_wr) n_valid = 1'b1;
        else if (i_out_ready) n_valid = 1'b0;
        else n_valid = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_valid;

    a_accept_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> r_state == S_CHK)
        else $error("accepted request did not start the range check");

    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!i_sts.mul_busy && !i_sts.div_busy))
        else $error("arithmetic unit still busy while idle");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> ($past(r_state) == S_OK || $past(r_state) == S_REJ
                            || $past(r_state) == S_GUP))
        else $error("result raised outside a result state");
endmodule
`default_nettype wire

// ----- tb/sf64_checker.sv -----
`default_nettype none
module sf64_checker import sf64_pkg::*; #(
    parameter logic [31:0] MAX_STEPS = 32'd1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [63:0] i_number,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [63:0] i_small_factor,
    input  wire logic [63:0] i_large_factor,
    input  wire logic [1:0]  i_status,
    output int               o_fails,
    output int               o_pending,
    output int               o_checked
);

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [1:0]  st;
    } t_split;

    t_split split_q[$];

    function automatic logic [63:0] mod_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] m);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[63:0];
    endfunction

    function automatic logic [63:0] mod_mul(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd0;
        a = a % m;
        while (b != 64'd0) begin
            if (b[0])
                acc = mod_add(acc, a, m);
            a = mod_add(a, a, m);
            b = b >> 1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] mod_pow(input logic [63:0] b, input logic [63:0] e,
                                            input logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1 % m;
        b = b % m;
        while (e != 64'd0) begin
            if (e[0])
                acc = mod_mul(acc, b, m);
            b = mod_mul(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic [63:0] gcd(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        while (b != 64'd0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic bit prime_test(input logic [63:0] n);
        logic [63:0] tp[12];
        logic [63:0] wb[7];
        logic [63:0] d;
        logic [63:0] w;
        int s;
        int k;
        tp = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17, 64'd19,
               64'd23, 64'd29, 64'd31, 64'd37};
        wb = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504,
               64'd1795265022};
        if (n < 64'd2)
            return 1'b0;
        for (int i = 0; i < 12; i++) begin
            if (n == tp[i])
                return 1'b1;
            if (n % tp[i] == 64'd0)
                return 1'b0;
        end
        d = n - 64'd1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        for (int i = 0; i < 7; i++) begin
            if (wb[i] % n != 64'd0) begin
                w = mod_pow(wb[i], d, n);
                if (w != 64'd1 && w != n - 64'd1) begin
                    k = 1;
                    while (k < s && w != n - 64'd1) begin
                        w = mod_mul(w, w, n);
                        k++;
                    end
                    if (w != n - 64'd1)
                        return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // zero means the search gave up
    function automatic logic [63:0] rho_divisor(input logic [63:0] n);
        logic [63:0] steps;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] g;
        logic [63:0] span;
        steps = 64'd0;
        if (!n[0])
            return 64'd2;
        for (logic [63:0] c = 64'd1; c < n; c++) begin
            x = 64'd2;
            y = 64'd2;
            g = 64'd1;
            while (g == 64'd1) begin
                if (steps >= {32'd0, MAX_STEPS})
                    return 64'd0;
                steps++;
                x = mod_add(mod_mul(x, x, n), c, n);
                y = mod_add(mod_mul(y, y, n), c, n);
                y = mod_add(mod_mul(y, y, n), c, n);
                span = (x > y) ? x - y : y - x;
                g = gcd(span, n);
            end
            if (g != n)
                return g;
        end
        return 64'd0;
    endfunction

    function automatic t_split factorize(input logic [63:0] n);
        t_split r;
        logic [63:0] f;
        logic [63:0] o;
        r = '{lo: 64'd0, hi: 64'd0, st: ST_REJECT};
        if (n < 64'd4 || prime_test(n))
            return r;
        f = rho_divisor(n);
        if (f == 64'd0) begin
            r.st = ST_GAVEUP;
            return r;
        end
        o = n / f;
        r.lo = (f < o) ? f : o;
        r.hi = (f < o) ? o : f;
        r.st = ST_OK;
        return r;
    endfunction

    assign o_pending = split_q.size();

    always @(posedge i_clk) begin
        t_split exp_r;
        if (!i_rst_n) begin
            split_q.delete();
            o_fails   <= 0;
            o_checked <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                split_q.insert(split_q.size(), factorize(i_number));
            if (i_out_valid && i_out_ready) begin
                o_checked <= o_checked + 1;
                if (split_q.size() == 0) begin
                    $display("%0t: unexpected result %h %h %0d", $time,
                             i_small_factor, i_large_factor, i_status);
                    o_fails <= o_fails + 1;
                end else begin
                    exp_r = split_q.pop_front();
                    if (exp_r.lo !== i_small_factor || exp_r.hi !== i_large_factor
                            || exp_r.st !== i_status) begin
                        $display("%0t: expected %h %h %0d, got %h %h %0d", $time,
                                 exp_r.lo, exp_r.hi, exp_r.st,
                                 i_small_factor, i_large_factor, i_status);
                        o_fails <= o_fails + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
module tb;
    import sf64_pkg::*;

    // small step cap so that a give-up is reachable in simulation
    localparam logic [31:0] STEP_CAP   = 32'd1024;
    localparam longint      CYCLE_CAP  = 64'd4_000_000_000;
    localparam int          HOLD_LEN   = 150_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [63:0] i_number = 64'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_small_factor;
    logic [63:0] o_large_factor;
    logic [1:0]  o_status;

    int     fails;
    int     pending;
    int     checked;
    int     sent = 0;
    longint cycles = 0;
    logic   req_taken = 1'b0;
    logic   long_hold = 1'b0;

    always #4 i_clk = ~i_clk;

    semiprime_factorizer_64 #(.MAX_STEPS(STEP_CAP)) u_dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_number,
        .o_out_valid, .i_out_ready, .o_small_factor, .o_large_factor, .o_status
    );

    sf64_checker #(.MAX_STEPS(STEP_CAP)) u_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_number,
        .i_out_valid(o_out_valid), .i_out_ready, .i_small_factor(o_small_factor),
        .i_large_factor(o_large_factor), .i_status(o_status),
        .o_fails(fails), .o_pending(pending), .o_checked(checked)
    );

    // note each accepted request, read back at the following falling edge
    always @(posedge i_clk) begin
        req_taken <= i_in_valid && o_in_ready;
        cycles    <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(30, 400);
    endfunction

    // receiver: random back-pressure, plus one long hold on request
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                long_hold = 1'b0;
                i_out_ready <= 1'b1;
            end else begin
                g = pick_gap();
                if (g == 0 || $urandom_range(0, 3) != 0) begin
                    i_out_ready <= 1'b1;
                end else begin
                    i_out_ready <= 1'b0;
                    repeat (g - 1) @(negedge i_clk);
                end
            end
        end
    end

    // offer one request and hold it until taken; call at a falling edge
    task automatic offer(input logic [63:0] n, input bit gaps);
        int g;
        i_in_valid <= 1'b1;
        i_number   <= n;
        do begin
            @(posedge i_clk);
            @(negedge i_clk);
        end while (!req_taken);
        sent++;
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    // mostly numbers with a small factor, so that the search ends soon
    function automatic logic [63:0] rand_number();
        int          kind;
        int          w;
        logic [63:0] a;
        logic [63:0] b;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            a = 64'($urandom_range(2, 4095));
            w = $urandom_range(2, 50);
            b = {$urandom, $urandom} >> (64 - w);
            return a * b;
        end else if (kind <= 7) begin
            return 64'($urandom_range(0, 2000));
        end else if (kind == 8) begin
            return {$urandom, $urandom} & ~64'd1;
        end
        return {$urandom, $urandom} >> 44 | 64'd1;
    endfunction

    initial begin
        logic [63:0] directed[$];
        directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd9, 64'd15,
                     64'd25, 64'd35, 64'd37, 64'd41, 64'd49, 64'd121, 64'd221,
                     64'd1369, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                     64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFC5,
                     64'd1000003 * 64'd1000033};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed cases: extremes, small numbers, primes, a hard semiprime
        foreach (directed[i])
            offer(directed[i], 1'b1);

        // pause until everything is back
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        // hold the receiver off while quick even requests keep coming
        long_hold = 1'b1;
        repeat (4) offer(rand_number() & ~64'd1, 1'b0);
        i_in_valid <= 1'b0;
        @(negedge i_clk);

        // random part
        repeat (74) offer(rand_number(), 1'b1);
        i_in_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (2000) @(negedge i_clk);

        $display("%0d requests sent, %0d results checked: small numbers, primes,", sent,
                 checked);
        $display("even and odd composites, give-up path and output back-pressure");
        if (fails == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
